// ===== hw/rtl/pva_pkg.sv =====
package pva_pkg;

   // request kinds
   localparam logic [1:0] REQ_VOTE    = 2'd0;
   localparam logic [1:0] REQ_RELEASE = 2'd1;
   localparam logic [1:0] REQ_STATUS  = 2'd2;

   // result codes
   localparam logic [2:0] RES_OK         = 3'd0;
   localparam logic [2:0] RES_BAD_USER   = 3'd1;
   localparam logic [2:0] RES_LINK_DOWN  = 3'd2;
   localparam logic [2:0] RES_VOTE_MAX   = 3'd3;
   localparam logic [2:0] RES_ERR_STATUS = 3'd4;
   localparam logic [2:0] RES_NO_VOTE    = 3'd5;
   localparam logic [2:0] RES_BAD_STATUS = 3'd6;

   // control register indexes
   localparam logic [1:0] CSR_ERROR_CODE = 2'd0;
   localparam logic [1:0] CSR_GPIO_USER  = 2'd1;
   localparam logic [1:0] CSR_I2C_USER   = 2'd2;

   // limits
   localparam logic [7:0]  VOTE_MAX     = 8'hFF;
   localparam logic [10:0] TOTAL_MAX    = 11'h7FF;
   localparam logic [31:0] CNT_MAX      = 32'hFFFF_FFFF;
   localparam logic [4:0]  STATUS_COUNT = 5'd8;

   // reset values of the control registers
   localparam logic [3:0] ERROR_CODE_RST = 4'd3;
   localparam logic [2:0] GPIO_USER_RST  = 3'd0;
   localparam logic [2:0] I2C_USER_RST   = 3'd1;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [3:0]  user_index;
      logic        link_ok;
      logic [3:0]  status_code;
      logic [31:0] now_ms;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  result_code;
      logic        l0_request_pulse;
      logic        l0_release_pulse;
      logic        recovery_done_pulse;
      logic [10:0] total_votes;
      logic [31:0] gpio_uses;
      logic [31:0] i2c_uses;
      logic [31:0] l0_held_ms;
   } rsp_payload_type;

endpackage

// ===== hw/rtl/power_vote_aggregator_unit.sv =====
// Reference-counted power vote. Each user holds an 8-bit vote count in a small
// synchronous memory (registered read); the running total, system status,
// usage counters and L0 hold timer live in registers. Every beat yields exactly
// one response beat. An item is handled in an accept and an execute step: the
// accept edge reads the user's count from the vote memory; the execute edge,
// taken once the response register is free, writes it back and loads the
// response register, and no new item is taken until then. The vote memory needs
// no clearing pass: a per-user valid bit, cleared by reset, makes an unwritten
// entry read as zero. The csr port is always ready, but control registers are
// to be written only while no item is in flight, as an item in execution sees
// the new value; writes to an unknown index are dropped.
module power_vote_aggregator_unit
   import pva_pkg::*;
#(
   parameter int USERS = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [1:0]      csr_index,
   input  logic [3:0]      csr_data
);

   localparam int IDX_W = $clog2(USERS);
   localparam logic [4:0] USERS_LIM = 5'(USERS);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   // vote memory and per-entry valid bits
   logic [7:0]       vote_mem [USERS];
   logic [7:0]       rd_data_ff;
   logic [USERS-1:0] vote_valid_ff, vote_valid_in;

   // control state
   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   req_payload_type item_ff;
   logic [31:0] held_diff_ff;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   // block state
   logic [10:0] total_ff, total_in;
   logic [3:0]  status_ff, status_in;
   logic        held_ff, held_in;
   logic [31:0] start_ff, start_in;
   logic [31:0] gpio_ff, gpio_in;
   logic [31:0] i2c_ff, i2c_in;
   logic [31:0] l0_time_ff, l0_time_in;

   // control registers
   logic [3:0] err_code_ff;
   logic [2:0] gpio_user_ff;
   logic [2:0] i2c_user_ff;

   logic             req_fire;
   logic             exec_fire;
   logic [IDX_W-1:0] req_idx;
   logic [IDX_W-1:0] item_idx;
   logic             in_range;
   logic [7:0]       cur_votes;
   logic [7:0]       new_votes;
   logic             mem_we;
   logic [32:0]      held_sum;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign exec_fire = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign req_idx   = req_payload.user_index[IDX_W-1:0];
   assign item_idx  = item_ff.user_index[IDX_W-1:0];
   assign in_range  = ({1'b0, item_ff.user_index} < USERS_LIM);
   assign cur_votes = (in_range && vote_valid_ff[item_idx]) ? rd_data_ff : 8'd0;
   assign held_sum  = {1'b0, l0_time_ff} + {1'b0, held_diff_ff};

   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // vote memory: read on accept, write back on execute
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_data_ff <= vote_mem[req_idx];
      end
      if (mem_we) begin
         vote_mem[item_idx] <= new_votes;
      end
   end

   // item capture; the hold time is taken at accept while the start mark is stable
   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff      <= req_payload;
         held_diff_ff <= req_payload.now_ms - start_ff;
      end
   end

   // item execution
   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      total_in       = total_ff;
      status_in      = status_ff;
      held_in        = held_ff;
      start_in       = start_ff;
      gpio_in        = gpio_ff;
      i2c_in         = i2c_ff;
      l0_time_in     = l0_time_ff;
      vote_valid_in  = vote_valid_ff;
      new_votes      = cur_votes;
      mem_we         = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_fire) begin
         state_in = ST_EXEC;
      end

      if (exec_fire) begin
         state_in                           = ST_IDLE;
         rsp_valid_in                       = 1'b1;
         rsp_payload_in.result_code         = RES_OK;
         rsp_payload_in.l0_request_pulse    = 1'b0;
         rsp_payload_in.l0_release_pulse    = 1'b0;
         rsp_payload_in.recovery_done_pulse = 1'b0;

         case (item_ff.req_type)
            REQ_VOTE: begin
               if (!in_range) begin
                  rsp_payload_in.result_code = RES_BAD_USER;
               end else begin
                  // usage counting happens before the remaining checks
                  if (item_ff.user_index[2:0] == gpio_user_ff
                      && item_ff.user_index[3] == 1'b0) begin
                     if (gpio_ff != CNT_MAX) begin
                        gpio_in = gpio_ff + 32'd1;
                     end
                  end else if (item_ff.user_index[2:0] == i2c_user_ff
                               && item_ff.user_index[3] == 1'b0) begin
                     if (i2c_ff != CNT_MAX) begin
                        i2c_in = i2c_ff + 32'd1;
                     end
                  end

                  if (!item_ff.link_ok) begin
                     rsp_payload_in.result_code = RES_LINK_DOWN;
                  end else if (cur_votes == VOTE_MAX || total_ff == TOTAL_MAX) begin
                     rsp_payload_in.result_code = RES_VOTE_MAX;
                  end else if (status_ff == err_code_ff) begin
                     rsp_payload_in.result_code = RES_ERR_STATUS;
                  end else begin
                     rsp_payload_in.l0_request_pulse = (total_ff == 11'd0);
                     new_votes               = cur_votes + 8'd1;
                     mem_we                  = 1'b1;
                     vote_valid_in[item_idx] = 1'b1;
                     total_in                = total_ff + 11'd1;
                     held_in                 = 1'b1;
                     start_in                = item_ff.now_ms;
                  end
               end
            end
            REQ_RELEASE: begin
               if (!in_range) begin
                  rsp_payload_in.result_code = RES_BAD_USER;
               end else if (cur_votes == 8'd0) begin
                  rsp_payload_in.result_code = RES_NO_VOTE;
               end else begin
                  new_votes               = cur_votes - 8'd1;
                  mem_we                  = 1'b1;
                  vote_valid_in[item_idx] = 1'b1;
                  if (total_ff != 11'd0) begin
                     total_in = total_ff - 11'd1;
                  end
                  if (total_in == 11'd0) begin
                     rsp_payload_in.l0_release_pulse    = 1'b1;
                     rsp_payload_in.recovery_done_pulse = (status_ff == err_code_ff);
                  end
                  // close the hold interval, saturating
                  if (held_ff) begin
                     held_in    = 1'b0;
                     l0_time_in = held_sum[32] ? CNT_MAX : held_sum[31:0];
                  end
               end
            end
            REQ_STATUS: begin
               if ({1'b0, item_ff.status_code} >= STATUS_COUNT) begin
                  rsp_payload_in.result_code = RES_BAD_STATUS;
               end else begin
                  status_in = item_ff.status_code;
               end
            end
            default: begin
            end
         endcase

         rsp_payload_in.total_votes = total_in;
         rsp_payload_in.gpio_uses   = gpio_in;
         rsp_payload_in.i2c_uses    = i2c_in;
         rsp_payload_in.l0_held_ms  = l0_time_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   // control and block state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         vote_valid_ff <= '0;
         total_ff      <= 11'd0;
         status_ff     <= 4'd0;
         held_ff       <= 1'b0;
         start_ff      <= 32'd0;
         gpio_ff       <= 32'd0;
         i2c_ff        <= 32'd0;
         l0_time_ff    <= 32'd0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         vote_valid_ff <= vote_valid_in;
         total_ff      <= total_in;
         status_ff     <= status_in;
         held_ff       <= held_in;
         start_ff      <= start_in;
         gpio_ff       <= gpio_in;
         i2c_ff        <= i2c_in;
         l0_time_ff    <= l0_time_in;
      end
   end

   // control register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         err_code_ff  <= ERROR_CODE_RST;
         gpio_user_ff <= GPIO_USER_RST;
         i2c_user_ff  <= I2C_USER_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ERROR_CODE: err_code_ff  <= csr_data;
            CSR_GPIO_USER:  gpio_user_ff <= csr_data[2:0];
            CSR_I2C_USER:   i2c_user_ff  <= csr_data[2:0];
            default: begin
            end
         endcase
      end
   end

endmodule

// ===== verif/tb_power_vote_aggregator_unit.sv =====
`timescale 1ns / 100ps

module tb_power_vote_aggregator_unit
   import pva_pkg::*;
();

   localparam int         N_USERS    = 8;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   // idling patterns
   localparam int IDLE_NONE   = 0;
   localparam int IDLE_SEND   = 1;
   localparam int IDLE_RECV   = 2;
   localparam int IDLE_BOTH   = 3;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_valid = 1'b0;
   logic            csr_ready;
   logic [1:0]      csr_index = CSR_ERROR_CODE;
   logic [3:0]      csr_data = '0;

   power_vote_aggregator_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   // clock, 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // run limit
   initial begin
      #5000000;
      $display("power_vote_aggregator_unit: mismatch");
      $finish;
   end

   req_payload_type pending_req[$];
   rsp_payload_type expected_rsp[$];
   int  idle_mode = IDLE_NONE;
   bit  hold_go = 1'b0;
   bit  hold_done = 1'b0;
   int  hold_left = 0;
   bit  req_fired = 1'b0;
   int  fault_count = 0;
   int  req_beats = 0;
   int  rsp_beats = 0;
   int  l0_req_seen = 0;
   int  l0_rel_seen = 0;
   int  recovery_seen = 0;
   int  busy_seen = 0;

   // predicted state of the block
   logic [7:0]  pred_votes[N_USERS];
   logic [10:0] vote_sum;
   logic [3:0]  sys_status;
   logic        held;
   logic [31:0] held_since;
   logic [31:0] pred_gpio_uses;
   logic [31:0] i2c_cnt;
   logic [31:0] held_total;
   logic [3:0]  err_code;
   logic [2:0]  gpio_id;
   logic [2:0]  i2c_id;

   // stimulus-side view of the settings and time
   logic [3:0]  stim_err = ERROR_CODE_RST;
   logic [31:0] stim_ms = 32'd0;

   function automatic rsp_payload_type tally_vote(req_payload_type it);
      rsp_payload_type r;
      logic [32:0]     held_sum;
      r = '0;
      r.result_code = RES_OK;
      case (it.req_type)
         REQ_VOTE: begin
            if (it.user_index >= N_USERS) begin
               r.result_code = RES_BAD_USER;
            end else begin
               // usage counting comes before the link and limit checks
               if (it.user_index == {1'b0, gpio_id}) begin
                  if (pred_gpio_uses != CNT_MAX) pred_gpio_uses = pred_gpio_uses + 1;
               end else if (it.user_index == {1'b0, i2c_id}) begin
                  if (i2c_cnt != CNT_MAX) i2c_cnt = i2c_cnt + 1;
               end
               if (!it.link_ok) begin
                  r.result_code = RES_LINK_DOWN;
               end else if (pred_votes[it.user_index] == VOTE_MAX ||
                            vote_sum >= TOTAL_MAX) begin
                  r.result_code = RES_VOTE_MAX;
               end else if (sys_status == err_code) begin
                  r.result_code = RES_ERR_STATUS;
               end else begin
                  r.l0_request_pulse = (vote_sum == 0);
                  pred_votes[it.user_index] = pred_votes[it.user_index] + 1;
                  vote_sum = vote_sum + 1;
                  held = 1'b1;
                  held_since = it.now_ms;
               end
            end
         end
         REQ_RELEASE: begin
            if (it.user_index >= N_USERS) begin
               r.result_code = RES_BAD_USER;
            end else if (pred_votes[it.user_index] == 0) begin
               r.result_code = RES_NO_VOTE;
            end else begin
               pred_votes[it.user_index] = pred_votes[it.user_index] - 1;
               if (vote_sum != 0) vote_sum = vote_sum - 1;
               if (vote_sum == 0) begin
                  r.l0_release_pulse = 1'b1;
                  r.recovery_done_pulse = (sys_status == err_code);
               end
               // hold time accrues on every accepted release while held, saturating
               if (held) begin
                  held = 1'b0;
                  held_sum = {1'b0, held_total} + {1'b0, it.now_ms - held_since};
                  held_total = held_sum[32] ? CNT_MAX : held_sum[31:0];
               end
            end
         end
         REQ_STATUS: begin
            if ({1'b0, it.status_code} >= STATUS_COUNT) r.result_code = RES_BAD_STATUS;
            else sys_status = it.status_code;
         end
         default: ;
      endcase
      r.total_votes = vote_sum;
      r.gpio_uses   = pred_gpio_uses;
      r.i2c_uses    = i2c_cnt;
      r.l0_held_ms  = held_total;
      return r;
   endfunction

   task automatic check_field(input string name, input longint exp_v, input longint act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         fault_count++;
      end
   endtask

   // monitor: checks response beats, tracks csr writes and predicts accepted beats
   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         foreach (pred_votes[i]) pred_votes[i] = '0;
         vote_sum       = '0;
         sys_status     = '0;
         held           = 1'b0;
         held_since     = '0;
         pred_gpio_uses = '0;
         i2c_cnt        = '0;
         held_total     = '0;
         err_code       = ERROR_CODE_RST;
         gpio_id        = GPIO_USER_RST;
         i2c_id         = I2C_USER_RST;
         req_fired      = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_beats++;
            if (expected_rsp.size() == 0) begin
               $error("response beat arrived with nothing outstanding");
               fault_count++;
            end else begin
               want = expected_rsp.pop_front();
               check_field("result_code", want.result_code, rsp_payload.result_code);
               check_field("l0_request_pulse", want.l0_request_pulse,
                           rsp_payload.l0_request_pulse);
               check_field("l0_release_pulse", want.l0_release_pulse,
                           rsp_payload.l0_release_pulse);
               check_field("recovery_done_pulse", want.recovery_done_pulse,
                           rsp_payload.recovery_done_pulse);
               check_field("total_votes", want.total_votes, rsp_payload.total_votes);
               check_field("gpio_uses", want.gpio_uses, rsp_payload.gpio_uses);
               check_field("i2c_uses", want.i2c_uses, rsp_payload.i2c_uses);
               check_field("l0_held_ms", want.l0_held_ms, rsp_payload.l0_held_ms);
               l0_req_seen   += want.l0_request_pulse;
               l0_rel_seen   += want.l0_release_pulse;
               recovery_seen += want.recovery_done_pulse;
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ERROR_CODE: err_code = csr_data;
               CSR_GPIO_USER:  gpio_id  = csr_data[2:0];
               CSR_I2C_USER:   i2c_id   = csr_data[2:0];
               default: ;
            endcase
         end
         if (req_valid && !req_ready) busy_seen++;
         req_fired = req_valid && req_ready;
         if (req_fired) begin
            req_beats++;
            expected_rsp.push_back(tally_vote(req_payload));
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      bit gap;
      gap = (idle_mode == IDLE_SEND && $urandom_range(0, 99) < 46) ||
            (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 18);
      if (!reset && (!req_valid || req_fired)) begin
         if (pending_req.size() > 0 && !gap) begin
            req_valid   <= 1'b1;
            req_payload <= pending_req.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response ready, with one long hold-off to back the block up
   always @(negedge clock) begin
      if (hold_go && !hold_done) begin
         hold_left = 400;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (idle_mode == IDLE_RECV) begin
         rsp_ready <= ($urandom_range(0, 99) >= 46);
      end else if (idle_mode == IDLE_BOTH) begin
         rsp_ready <= ($urandom_range(0, 99) >= 18);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic req_payload_type make_req(logic [1:0] kind, logic [3:0] user,
                                                logic link, logic [3:0] st, logic [31:0] ms);
      req_payload_type it;
      it.req_type    = kind;
      it.user_index  = user;
      it.link_ok     = link;
      it.status_code = st;
      it.now_ms      = ms;
      return it;
   endfunction

   task automatic write_csr(input logic [1:0] idx, input logic [3:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drain();
      do @(negedge clock);
      while (pending_req.size() != 0 || req_valid || expected_rsp.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic apply_settings(input logic [3:0] err, input logic [2:0] gpio,
                                 input logic [2:0] i2c);
      write_csr(CSR_ERROR_CODE, err);
      write_csr(CSR_GPIO_USER, {1'b0, gpio});
      write_csr(CSR_I2C_USER, {1'b0, i2c});
      stim_err = err;
   endtask

   // mostly well-formed vote traffic over a moving clock, with some noise
   task automatic queue_random(input int count);
      int          pick;
      logic [3:0]  user;
      logic [3:0]  st;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         user = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(8, 15))
                                             : 4'($urandom_range(0, 7));
         st = 4'($urandom);
         if ($urandom_range(0, 32) == 0) stim_ms = $urandom;
         else stim_ms = stim_ms + $urandom_range(0, 2000);
         if (pick < 42) begin
            pending_req.push_back(make_req(REQ_VOTE, user, ($urandom_range(0, 9) != 0),
                                           st, stim_ms));
         end else if (pick < 82) begin
            pending_req.push_back(make_req(REQ_RELEASE, user, 1'($urandom), st, stim_ms));
         end else if (pick < 93) begin
            if ($urandom_range(0, 3) == 0) st = stim_err;
            else if ($urandom_range(0, 5) != 0) st = 4'($urandom_range(0, 7));
            pending_req.push_back(make_req(REQ_STATUS, 4'($urandom), 1'($urandom),
                                           st, stim_ms));
         end else begin
            pending_req.push_back(make_req(REQ_UNUSED, 4'($urandom), 1'($urandom),
                                           st, $urandom));
         end
      end
   endtask

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // directed: noise, range checks, link down, wrap of the hold timer,
      // error status blocking votes and recovery on the last release
      pending_req.push_back(make_req(REQ_UNUSED, 4'd15, 1'b1, 4'd15, 32'hFFFF_FFFF));
      pending_req.push_back(make_req(REQ_VOTE, 4'd15, 1'b0, 4'd0, 32'd0));
      pending_req.push_back(make_req(REQ_RELEASE, 4'd8, 1'b1, 4'd0, 32'd0));
      pending_req.push_back(make_req(REQ_RELEASE, 4'd0, 1'b1, 4'd0, 32'd5));
      pending_req.push_back(make_req(REQ_STATUS, 4'd0, 1'b0, 4'd12, 32'd6));
      pending_req.push_back(make_req(REQ_VOTE, 4'd0, 1'b0, 4'd0, 32'd100));
      pending_req.push_back(make_req(REQ_VOTE, 4'd1, 1'b1, 4'd0, 32'd100));
      pending_req.push_back(make_req(REQ_VOTE, 4'd7, 1'b1, 4'd0, 32'hFFFF_FF00));
      pending_req.push_back(make_req(REQ_RELEASE, 4'd7, 1'b1, 4'd0, 32'h0000_0010));
      pending_req.push_back(make_req(REQ_RELEASE, 4'd1, 1'b1, 4'd0, 32'h0000_0020));
      pending_req.push_back(make_req(REQ_STATUS, 4'd0, 1'b1, ERROR_CODE_RST, 32'd30));
      pending_req.push_back(make_req(REQ_VOTE, 4'd2, 1'b1, 4'd0, 32'd40));
      pending_req.push_back(make_req(REQ_STATUS, 4'd0, 1'b1, 4'd0, 32'd50));
      pending_req.push_back(make_req(REQ_VOTE, 4'd2, 1'b1, 4'd0, 32'd1000));
      pending_req.push_back(make_req(REQ_VOTE, 4'd2, 1'b1, 4'd0, 32'd1500));
      pending_req.push_back(make_req(REQ_STATUS, 4'd0, 1'b1, ERROR_CODE_RST, 32'd1600));
      pending_req.push_back(make_req(REQ_RELEASE, 4'd2, 1'b1, 4'd0, 32'd2000));
      pending_req.push_back(make_req(REQ_RELEASE, 4'd2, 1'b1, 4'd0, 32'd2100));
      pending_req.push_back(make_req(REQ_STATUS, 4'd0, 1'b0, 4'd7, 32'd2200));
      pending_req.push_back(make_req(REQ_STATUS, 4'd0, 1'b0, 4'd8, 32'd2300));
      pending_req.push_back(make_req(REQ_STATUS, 4'd0, 1'b0, 4'd0, 32'd2400));
      pending_req.push_back(make_req(REQ_VOTE, 4'd0, 1'b1, 4'd0, 32'd2500));
      pending_req.push_back(make_req(REQ_RELEASE, 4'd0, 1'b1, 4'd0, 32'd2600));
      stim_ms = 32'd2600;
      wait_drain();

      // random traffic at reset settings, no idling
      queue_random(300);
      wait_drain();

      // gpio and i2c on the same user, sender idling
      apply_settings(4'd5, 3'd3, 3'd3);
      idle_mode = IDLE_SEND;
      queue_random(300);
      wait_drain();

      // lowest error code, receiver stalling plus one long hold-off
      apply_settings(4'd0, 3'd7, 3'd0);
      idle_mode = IDLE_RECV;
      hold_go = 1'b1;
      queue_random(300);
      wait_drain();

      // highest error code, never reachable as a status, both sides idling
      apply_settings(4'd15, 3'd0, 3'd7);
      idle_mode = IDLE_BOTH;
      queue_random(300);
      wait_drain();

      // drive one user to its vote ceiling and back past zero
      apply_settings(4'd15, 3'd4, 3'd2);
      idle_mode = IDLE_NONE;
      pending_req.push_back(make_req(REQ_STATUS, 4'd0, 1'b1, 4'd0, stim_ms));
      for (int n = 0; n < 260; n++) begin
         stim_ms = stim_ms + $urandom_range(0, 50);
         pending_req.push_back(make_req(REQ_VOTE, 4'd4, 1'b1, 4'($urandom), stim_ms));
      end
      for (int n = 0; n < 262; n++) begin
         stim_ms = stim_ms + $urandom_range(0, 50);
         pending_req.push_back(make_req(REQ_RELEASE, 4'd4, 1'($urandom), 4'($urandom),
                                        stim_ms));
      end
      wait_drain();

      // back to reset settings, both sides idling
      apply_settings(ERROR_CODE_RST, GPIO_USER_RST, I2C_USER_RST);
      idle_mode = IDLE_BOTH;
      queue_random(150);
      wait_drain();

      // push the hold timer into saturation
      idle_mode = IDLE_NONE;
      pending_req.push_back(make_req(REQ_STATUS, 4'd0, 1'b1, 4'd0, 32'd0));
      for (int n = 0; n < 2; n++) begin
         pending_req.push_back(make_req(REQ_VOTE, 4'd5, 1'b1, 4'd0, 32'd0));
         pending_req.push_back(make_req(REQ_RELEASE, 4'd5, 1'b1, 4'd0, 32'hFFFF_FFFF));
      end
      wait_drain();
      repeat (20) @(negedge clock);

      if (expected_rsp.size() != 0) begin
         $error("%0d responses never arrived", expected_rsp.size());
         fault_count++;
      end
      $display("covered %0d request beats and %0d response beats over four idling patterns",
               req_beats, rsp_beats);
      $display("saw %0d L0 requests, %0d L0 releases, %0d recoveries, %0d input stalls",
               l0_req_seen, l0_rel_seen, recovery_seen, busy_seen);
      if (fault_count == 0) begin
         $display("power_vote_aggregator_unit: match");
      end else begin
         $display("power_vote_aggregator_unit: mismatch");
      end
      $finish;
   end

endmodule
